// File: design/telemetry_frame_deframer_defines.svh
// ----------------------------------------------------------------------------
// Telemetry frame deframer assertion macros
// Shared concurrent assertion forms used by the deframer top level.
// ----------------------------------------------------------------------------
`ifndef TELEMETRY_FRAME_DEFRAMER_DEFINES_SVH
`define TELEMETRY_FRAME_DEFRAMER_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted
`define TFD_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted
`define TFD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: design/tfd_pkg.sv
// ----------------------------------------------------------------------------
// Telemetry frame deframer package
// Types, framing constants and the short-payload lookup.
// ----------------------------------------------------------------------------
package tfd_pkg;

	typedef enum logic [1:0] {
		PHASE_HUNT   = 2'd0,
		PHASE_HEADER = 2'd1,
		PHASE_BODY   = 2'd2
	} phase_t;

	typedef enum logic [1:0] {
		STATUS_OK    = 2'd0,
		STATUS_SHORT = 2'd1,
		STATUS_TRUNC = 2'd2
	} status_t;

	localparam logic [7:0] START_V1 = 8'hFE;
	localparam logic [7:0] START_V2 = 8'hFD;
	localparam logic [9:0] HEADER_V1 = 10'd6;
	localparam logic [9:0] HEADER_V2 = 10'd10;
	localparam logic [9:0] CHECKSUM_BYTES = 10'd2;
	localparam logic [9:0] SIGNATURE_BYTES = 10'd13;
	localparam logic [7:0] SIGNED_FLAG_MASK = 8'h01;

	localparam int NUM_KNOWN = 7;
	localparam logic [23:0] KNOWN_ID [NUM_KNOWN] = '{
		24'd0, 24'd30, 24'd33, 24'd100, 24'd106, 24'd132, 24'd141
	};
	localparam logic [7:0] KNOWN_MIN [NUM_KNOWN] = '{
		8'd9, 8'd16, 8'd20, 8'd26, 8'd44, 8'd10, 8'd24
	};

	// Outcome of one processed beat
	typedef struct packed {
		logic          emit;
		status_t       status;
		logic          version;
		logic [23:0]   ident;
		logic [7:0]    length;
		logic          sig;
	} tfd_event_t;

	// Payload shorter than the minimum of a known message id
	function automatic logic is_short(input logic [23:0] id, input logic [7:0] len);
		logic hit;
		hit = 1'b0;
		for (int i = 0; i < NUM_KNOWN; i++) begin
			if (id == KNOWN_ID[i] && len < KNOWN_MIN[i]) begin
				hit = 1'b1;
			end
		end
		return hit;
	endfunction

endpackage

// File: design/tfd_in_if.sv
// ----------------------------------------------------------------------------
// Deframer byte channel
// Valid/ready channel carrying one capture byte per beat.
// ----------------------------------------------------------------------------
interface tfd_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       end_of_capture;

	modport source (output valid, output data_byte, output end_of_capture, input ready);
	modport sink (input valid, input data_byte, input end_of_capture, output ready);
endinterface

// File: design/tfd_out_if.sv
// ----------------------------------------------------------------------------
// Deframer record channel
// Valid/ready channel carrying one frame record per beat.
// ----------------------------------------------------------------------------
interface tfd_out_if;
	logic        valid;
	logic        ready;
	logic        protocol_version;
	logic [23:0] message_ident;
	logic [7:0]  payload_length;
	logic        has_signature;
	logic [1:0]  frame_status;
	logic [31:0] frames_total;
	logic [31:0] malformed_total;

	modport source (
		output valid, output protocol_version, output message_ident,
		output payload_length, output has_signature, output frame_status,
		output frames_total, output malformed_total, input ready
	);
	modport sink (
		input valid, input protocol_version, input message_ident,
		input payload_length, input has_signature, input frame_status,
		input frames_total, input malformed_total, output ready
	);
endinterface

// File: design/tfd_in_stage.sv
// ----------------------------------------------------------------------------
// Deframer input stage
// Registers one incoming byte beat ahead of the parser.
// ----------------------------------------------------------------------------
module tfd_in_stage (
	input  logic       clk,
	input  logic       arst_n,
	tfd_in_if.sink     byte_in,
	input  logic       adv,
	output logic       valid_s1,
	output logic [7:0] data_s1,
	output logic       eoc_s1
);

	// Take a beat when the stage is empty or is draining this cycle
	assign byte_in.ready = !valid_s1 || adv;

	// Hold the valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (byte_in.ready) begin
			valid_s1 <= byte_in.valid;
		end
	end

	// Capture the byte and its end marker
	always_ff @(posedge clk) begin
		if (byte_in.ready && byte_in.valid) begin
			data_s1 <= byte_in.data_byte;
			eoc_s1  <= byte_in.end_of_capture;
		end
	end

endmodule

// File: design/tfd_parser.sv
// ----------------------------------------------------------------------------
// Deframer frame parser
// Tracks the frame phase and header fields and decides when a record is due.
// ----------------------------------------------------------------------------
module tfd_parser (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               adv,
	input  logic [7:0]         data_s1,
	input  logic               eoc_s1,
	output tfd_pkg::tfd_event_t evt
);
	import tfd_pkg::*;

	phase_t      phase_q, phase_n;
	logic        version_q, version_n;
	logic [8:0]  pos_q, pos_n;
	logic [7:0]  len_q, len_n;
	logic        sig_q, sig_n;
	logic [23:0] id_q, id_n;
	logic [9:0]  hdr;
	logic [9:0]  total;
	logic [9:0]  pos_inc;

	// Work out the next frame state and any record for this beat
	always_comb begin
		phase_n   = phase_q;
		version_n = version_q;
		pos_n     = pos_q;
		len_n     = len_q;
		sig_n     = sig_q;
		id_n      = id_q;
		hdr       = version_q ? HEADER_V2 : HEADER_V1;
		total     = '0;
		pos_inc   = {1'b0, pos_q} + 10'd1;
		evt       = '0;

		case (phase_q)
			PHASE_HUNT: begin
				if (data_s1 inside {START_V1, START_V2}) begin
					version_n = (data_s1 == START_V2);
					len_n     = '0;
					sig_n     = 1'b0;
					id_n      = '0;
					if (eoc_s1) begin
						evt.emit   = 1'b1;
						evt.status = STATUS_TRUNC;
					end else begin
						phase_n = PHASE_HEADER;
						pos_n   = 9'd1;
					end
				end
			end
			default: begin
				// Pick up header fields at their byte positions
				if (pos_q == 9'd1) begin
					len_n = data_s1;
				end else if (version_q) begin
					case (pos_q)
						9'd2: sig_n = |(data_s1 & SIGNED_FLAG_MASK);
						9'd7: id_n[7:0] = data_s1;
						9'd8: id_n[15:8] = data_s1;
						9'd9: id_n[23:16] = data_s1;
						default: ;
					endcase
				end else if (pos_q == 9'd5) begin
					id_n = {16'd0, data_s1};
				end

				total = hdr + {2'b00, len_n} + CHECKSUM_BYTES +
					(sig_n ? SIGNATURE_BYTES : 10'd0);

				if (pos_inc >= total) begin
					// Last byte of the frame
					evt.emit   = 1'b1;
					evt.status = is_short(id_n, len_n) ? STATUS_SHORT : STATUS_OK;
					phase_n    = PHASE_HUNT;
					pos_n      = '0;
				end else if (eoc_s1) begin
					evt.emit   = 1'b1;
					evt.status = STATUS_TRUNC;
					phase_n    = PHASE_HUNT;
					pos_n      = '0;
				end else begin
					pos_n   = pos_inc[8:0];
					phase_n = (pos_inc >= hdr) ? PHASE_BODY : PHASE_HEADER;
				end
			end
		endcase

		evt.version = version_n;
		evt.ident   = id_n;
		evt.length  = len_n;
		evt.sig     = sig_n;
	end

	// Advance the frame state on each processed beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PHASE_HUNT;
			version_q <= 1'b0;
			pos_q     <= '0;
			len_q     <= '0;
			sig_q     <= 1'b0;
			id_q      <= '0;
		end else if (adv) begin
			phase_q   <= phase_n;
			version_q <= version_n;
			pos_q     <= pos_n;
			len_q     <= len_n;
			sig_q     <= sig_n;
			id_q      <= id_n;
		end
	end

endmodule

// File: design/tfd_result.sv
// ----------------------------------------------------------------------------
// Deframer result stage
// Saturating frame counters and the registered record output.
// ----------------------------------------------------------------------------
module tfd_result #(
	parameter int COUNT_WIDTH = 32
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                adv,
	input  tfd_pkg::tfd_event_t evt,
	tfd_out_if.source           rec_out
);
	import tfd_pkg::*;

	logic [COUNT_WIDTH-1:0] frames_q, frames_n;
	logic [COUNT_WIDTH-1:0] malformed_q, malformed_n;
	logic                   load;

	assign load = adv && evt.emit;

	// Bump the counters, holding at full scale
	always_comb begin
		frames_n    = frames_q;
		malformed_n = malformed_q;
		if (evt.status != STATUS_TRUNC && frames_q != '1) begin
			frames_n = frames_q + 1'b1;
		end
		if (evt.status != STATUS_OK && malformed_q != '1) begin
			malformed_n = malformed_q + 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frames_q      <= '0;
			malformed_q   <= '0;
			rec_out.valid <= 1'b0;
		end else begin
			if (load) begin
				frames_q    <= frames_n;
				malformed_q <= malformed_n;
			end
			if (load) begin
				rec_out.valid <= 1'b1;
			end else if (rec_out.ready) begin
				rec_out.valid <= 1'b0;
			end
		end
	end

	// Load the record register
	always_ff @(posedge clk) begin
		if (load) begin
			rec_out.protocol_version <= evt.version;
			rec_out.message_ident    <= evt.ident;
			rec_out.payload_length   <= evt.length;
			rec_out.has_signature    <= evt.sig;
			rec_out.frame_status     <= evt.status;
			rec_out.frames_total     <= 32'(frames_n);
			rec_out.malformed_total  <= 32'(malformed_n);
		end
	end

endmodule

// File: design/telemetry_frame_deframer.sv
// ----------------------------------------------------------------------------
// Telemetry frame deframer
// Frames a byte capture as version 1 / version 2 telemetry traffic.
// ----------------------------------------------------------------------------
// Takes one capture byte per beat and emits one record per completed frame, or
// a truncated record when the end-of-capture byte arrives mid-frame. A byte is
// accepted every clock cycle while records are taken; the byte that finishes a
// frame is held in the input register, then the parser writes its record into
// the record register. The record register holds one result, and a full record
// register that is not being taken stalls the parser and so the byte input.
// Frame and malformed counters saturate at 2^COUNT_WIDTH - 1 and are reported
// in their low 32 bits. Checksums and signatures are skipped, not checked.
`include "telemetry_frame_deframer_defines.svh"

module telemetry_frame_deframer #(
	parameter int COUNT_WIDTH = 32
) (
	input  logic      clk,
	input  logic      arst_n,
	tfd_in_if.sink    byte_in,
	tfd_out_if.source rec_out
);
	import tfd_pkg::*;

	logic       valid_s1;
	logic [7:0] data_s1;
	logic       eoc_s1;
	logic       adv;
	tfd_event_t evt;

	// Process the held beat when the record register can take a result
	assign adv = valid_s1 && (!rec_out.valid || rec_out.ready);

	tfd_in_stage u_in_stage (
		.clk      (clk),
		.arst_n   (arst_n),
		.byte_in  (byte_in),
		.adv      (adv),
		.valid_s1 (valid_s1),
		.data_s1  (data_s1),
		.eoc_s1   (eoc_s1)
	);

	tfd_parser u_parser (
		.clk     (clk),
		.arst_n  (arst_n),
		.adv     (adv),
		.data_s1 (data_s1),
		.eoc_s1  (eoc_s1),
		.evt     (evt)
	);

	tfd_result #(
		.COUNT_WIDTH (COUNT_WIDTH)
	) u_result (
		.clk     (clk),
		.arst_n  (arst_n),
		.adv     (adv),
		.evt     (evt),
		.rec_out (rec_out)
	);

	// Checks
	`TFD_ASSERT_SAME(a_stall_holds_parser, clk, arst_n, rec_out.valid && !rec_out.ready, !adv, "parser advanced while record stalled")
	`TFD_ASSERT_SAME(a_ready_only_when_free, clk, arst_n, !byte_in.ready, valid_s1 && !adv, "byte input stalled with free stage")
	`TFD_ASSERT_NEXT(a_counts_hold_idle, clk, arst_n, !(adv && evt.emit), $stable(rec_out.frames_total) && $stable(rec_out.malformed_total), "counters moved without a record")

endmodule

// File: verif/telemetry_frame_deframer_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Telemetry frame deframer testbench
// Sends version 1 and version 2 frames, noise and cut-off captures one byte
// per beat with random gaps, while the record side stalls at random. A
// built-in parser model predicts every record, and each record taken from
// the block is checked field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module telemetry_frame_deframer_tb;
	import tfd_pkg::*;

	localparam int CYCLE_LIMIT = 400000;
	localparam int RANDOM_BYTES = 150;
	localparam int SETTLE_CYCLES = 8;

	// Where a frame carries its end-of-capture mark
	localparam int END_NONE = -1;
	localparam int END_RANDOM = -2;
	localparam int END_ON_LAST = -3;

	typedef struct {
		logic        version;
		logic [23:0] ident;
		logic [7:0]  length;
		logic        sig;
		status_t     status;
		logic [31:0] frames;
		logic [31:0] malformed;
	} frame_record_t;

	logic clk;
	logic arst_n;

	tfd_in_if  byte_ch ();
	tfd_out_if rec_ch ();

	telemetry_frame_deframer DUT (
		.clk     (clk),
		.arst_n  (arst_n),
		.byte_in (byte_ch),
		.rec_out (rec_ch)
	);

	// Parser model state
	phase_t      mdl_phase;
	logic        mdl_v2;
	logic [8:0]  mdl_pos;
	logic [7:0]  mdl_len;
	logic        mdl_sig;
	logic [23:0] mdl_ident;
	logic [31:0] mdl_frames;
	logic [31:0] mdl_malformed;

	frame_record_t expected_records[$];
	int            error_count;
	int            bytes_sent;
	int            cycle_count;
	int            stall_left;
	bit            quiet;

	// Clock
	always begin
		clk = 1'b0;
		#2;
		clk = 1'b1;
		#2;
	end

	// Saturating count step
	function automatic logic [31:0] count_step(input logic [31:0] v);
		return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
	endfunction

	// Length below the minimum of a known message id
	function automatic bit below_known_minimum(input logic [23:0] id, input logic [7:0] len);
		bit hit;
		hit = 1'b0;
		foreach (KNOWN_ID[k]) begin
			if (KNOWN_ID[k] == id)
				hit = (len < KNOWN_MIN[k]);
		end
		return hit;
	endfunction

	function automatic void queue_record(input status_t status);
		frame_record_t r;
		r.version = mdl_v2;
		r.ident = mdl_ident;
		r.length = mdl_len;
		r.sig = mdl_sig;
		r.status = status;
		r.frames = mdl_frames;
		r.malformed = mdl_malformed;
		expected_records.push_back(r);
	endfunction

	// Advance the parser model by one accepted byte
	function automatic void advance_parser(input logic [7:0] b, input logic eoc);
		logic [9:0] hdr;
		logic [9:0] span;
		logic [9:0] next_pos;
		status_t    status;
		if (mdl_phase == PHASE_HUNT) begin
			if (b != START_V1 && b != START_V2)
				return;
			mdl_v2 = (b == START_V2);
			mdl_len = '0;
			mdl_sig = 1'b0;
			mdl_ident = '0;
			mdl_pos = 9'd1;
			mdl_phase = PHASE_HEADER;
			if (eoc) begin
				mdl_malformed = count_step(mdl_malformed);
				queue_record(STATUS_TRUNC);
				mdl_phase = PHASE_HUNT;
				mdl_pos = '0;
			end
			return;
		end
		hdr = mdl_v2 ? HEADER_V2 : HEADER_V1;
		// capture header fields
		if (mdl_pos == 9'd1) begin
			mdl_len = b;
		end else if (mdl_v2) begin
			case (mdl_pos)
				9'd2: mdl_sig = |(b & SIGNED_FLAG_MASK);
				9'd7: mdl_ident[7:0] = b;
				9'd8: mdl_ident[15:8] = b;
				9'd9: mdl_ident[23:16] = b;
				default: ;
			endcase
		end else if (mdl_pos == 9'd5) begin
			mdl_ident = {16'h0, b};
		end
		span = hdr + {2'b0, mdl_len} + CHECKSUM_BYTES + (mdl_sig ? SIGNATURE_BYTES : 10'd0);
		next_pos = {1'b0, mdl_pos} + 10'd1;
		// last byte of the frame
		if (next_pos >= span) begin
			status = below_known_minimum(mdl_ident, mdl_len) ? STATUS_SHORT : STATUS_OK;
			mdl_frames = count_step(mdl_frames);
			if (status == STATUS_SHORT)
				mdl_malformed = count_step(mdl_malformed);
			queue_record(status);
			mdl_phase = PHASE_HUNT;
			mdl_pos = '0;
			return;
		end
		mdl_pos = next_pos[8:0];
		mdl_phase = (next_pos >= hdr) ? PHASE_BODY : PHASE_HEADER;
		if (eoc) begin
			mdl_malformed = count_step(mdl_malformed);
			queue_record(STATUS_TRUNC);
			mdl_phase = PHASE_HUNT;
			mdl_pos = '0;
		end
	endfunction

	// Mostly short idle stretches, a few long ones
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (quiet || r < 60)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 8);
		return $urandom_range(10, 30);
	endfunction

	// Offer one byte and hold it until the block takes it
	task automatic send_byte(input logic [7:0] b, input logic eoc);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			byte_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		byte_ch.valid <= 1'b1;
		byte_ch.data_byte <= b;
		byte_ch.end_of_capture <= eoc;
		do @(posedge clk); while (!byte_ch.ready);
		advance_parser(b, eoc);
		bytes_sent++;
	endtask

	// Build one frame and send it, marking the capture end where asked
	task automatic send_frame(input bit v2, input logic [7:0] len, input logic [23:0] ident,
			input bit sig_flag, input int end_at, input bit start_fill);
		logic [7:0] frame_bytes[$];
		int         last;
		int         cut;
		frame_bytes.push_back(v2 ? START_V2 : START_V1);
		frame_bytes.push_back(len);
		if (v2) begin
			frame_bytes.push_back({7'($urandom_range(0, 127)), sig_flag});
			repeat (4) frame_bytes.push_back(8'($urandom));
			frame_bytes.push_back(ident[7:0]);
			frame_bytes.push_back(ident[15:8]);
			frame_bytes.push_back(ident[23:16]);
		end else begin
			repeat (3) frame_bytes.push_back(8'($urandom));
			frame_bytes.push_back(ident[7:0]);
		end
		for (int i = 0; i < len; i++) begin
			if (start_fill)
				frame_bytes.push_back(i[0] ? START_V2 : START_V1);
			else
				frame_bytes.push_back(8'($urandom));
		end
		repeat (2) frame_bytes.push_back(8'($urandom));
		if (v2 && sig_flag)
			repeat (13) frame_bytes.push_back(8'($urandom));
		last = frame_bytes.size() - 1;
		case (end_at)
			END_NONE: cut = -1;
			END_RANDOM: cut = $urandom_range(0, last - 1);
			END_ON_LAST: cut = last;
			default: cut = end_at;
		endcase
		for (int i = 0; i <= last && (cut < 0 || i <= cut); i++)
			send_byte(frame_bytes[i], i == cut);
	endtask

	// Drop valid and wait for every predicted record
	task automatic drain_records();
		byte_ch.valid <= 1'b0;
		@(posedge clk);
		while (expected_records.size() != 0)
			@(posedge clk);
	endtask

	task automatic test_header_extremes();
		send_frame(1'b0, 8'd0, 24'd1, 1'b0, END_NONE, 1'b0);
		send_frame(1'b1, 8'd1, 24'hABCDEF, 1'b0, END_NONE, 1'b0);
		send_frame(1'b1, 8'd0, 24'hFFFFFF, 1'b1, END_NONE, 1'b0);
		send_frame(1'b0, 8'd255, 24'd255, 1'b0, END_NONE, 1'b0);
		send_frame(1'b1, 8'd255, 24'h000000, 1'b1, END_NONE, 1'b0);
	endtask

	// Each known id just below and at its minimum length
	task automatic test_short_payloads();
		for (int k = 0; k < NUM_KNOWN; k++) begin
			send_frame(k[0], KNOWN_MIN[k] - 8'd1, KNOWN_ID[k], k == 3, END_NONE, 1'b0);
			send_frame(!k[0], KNOWN_MIN[k], KNOWN_ID[k], 1'b0, END_NONE, 1'b0);
		end
	endtask

	task automatic test_capture_end();
		// end while hunting: no record
		send_byte(8'h55, 1'b1);
		// end on a start byte
		send_byte(START_V1, 1'b1);
		send_byte(START_V2, 1'b1);
		// end inside the id bytes, inside the payload, and on the last byte
		send_frame(1'b1, 8'd20, 24'h123456, 1'b1, 8, 1'b0);
		send_frame(1'b0, 8'd12, 24'd33, 1'b0, 9, 1'b0);
		send_frame(1'b1, 8'd3, 24'hFFFFFF, 1'b1, END_ON_LAST, 1'b0);
		// start bytes inside a payload are plain data
		send_frame(1'b0, 8'd6, 24'd7, 1'b0, END_NONE, 1'b1);
	endtask

	// Hold the sender until the record side has caught up
	task automatic test_drain_pause();
		send_frame(1'b1, 8'd4, 24'd132, 1'b0, END_NONE, 1'b0);
		drain_records();
		send_frame(1'b0, 8'd30, 24'd100, 1'b0, END_NONE, 1'b0);
	endtask

	task automatic test_random_traffic();
		int          goal;
		int          r;
		bit          v2;
		logic [7:0]  len;
		logic [23:0] ident;
		goal = bytes_sent + RANDOM_BYTES;
		while (bytes_sent < goal) begin
			quiet = ($urandom_range(0, 9) == 0);
			r = $urandom_range(0, 99);
			if (r < 10) begin
				// noise, now and then closing the capture
				repeat ($urandom_range(1, 6))
					send_byte(8'($urandom), $urandom_range(0, 4) == 0);
			end else begin
				v2 = 1'($urandom_range(0, 1));
				case ($urandom_range(0, 19))
					0: len = 8'($urandom_range(121, 255));
					1, 2: len = 8'($urandom_range(41, 120));
					default: len = 8'($urandom_range(0, 40));
				endcase
				if ($urandom_range(0, 1))
					ident = KNOWN_ID[$urandom_range(0, NUM_KNOWN - 1)];
				else
					ident = v2 ? 24'($urandom) : {16'h0, 8'($urandom)};
				send_frame(v2, len, ident, 1'($urandom_range(0, 1)),
					(r < 20) ? END_RANDOM : (r < 25) ? END_ON_LAST : END_NONE, 1'b0);
			end
			if ($urandom_range(0, 39) == 0)
				drain_records();
		end
		quiet = 1'b0;
	endtask

	// Record side: random stalls, taken beats checked against the model
	always @(posedge clk) begin
		frame_record_t exp_rec;
		if (arst_n && rec_ch.valid && rec_ch.ready) begin
			if (expected_records.size() == 0) begin
				$error("record beat with no frame pending");
				error_count++;
			end else begin
				exp_rec = expected_records.pop_front();
				if (rec_ch.protocol_version !== exp_rec.version) begin
					$error("protocol_version: expected %0d, got %0d",
						exp_rec.version, rec_ch.protocol_version);
					error_count++;
				end
				if (rec_ch.message_ident !== exp_rec.ident) begin
					$error("message_ident: expected %0h, got %0h",
						exp_rec.ident, rec_ch.message_ident);
					error_count++;
				end
				if (rec_ch.payload_length !== exp_rec.length) begin
					$error("payload_length: expected %0d, got %0d",
						exp_rec.length, rec_ch.payload_length);
					error_count++;
				end
				if (rec_ch.has_signature !== exp_rec.sig) begin
					$error("has_signature: expected %0d, got %0d",
						exp_rec.sig, rec_ch.has_signature);
					error_count++;
				end
				if (rec_ch.frame_status !== exp_rec.status) begin
					$error("frame_status: expected %0d, got %0d",
						exp_rec.status, rec_ch.frame_status);
					error_count++;
				end
				if (rec_ch.frames_total !== exp_rec.frames) begin
					$error("frames_total: expected %0d, got %0d",
						exp_rec.frames, rec_ch.frames_total);
					error_count++;
				end
				if (rec_ch.malformed_total !== exp_rec.malformed) begin
					$error("malformed_total: expected %0d, got %0d",
						exp_rec.malformed, rec_ch.malformed_total);
					error_count++;
				end
			end
		end
		// pick the next ready level
		if (!arst_n) begin
			rec_ch.ready <= 1'b0;
		end else if (quiet) begin
			stall_left = 0;
			rec_ch.ready <= 1'b1;
		end else if (stall_left > 0) begin
			stall_left--;
			rec_ch.ready <= 1'b0;
		end else begin
			rec_ch.ready <= 1'b1;
			if ($urandom_range(0, 4) == 0)
				stall_left = pick_gap();
		end
	end

	// Watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		byte_ch.valid = 1'b0;
		byte_ch.data_byte = '0;
		byte_ch.end_of_capture = 1'b0;
		rec_ch.ready = 1'b0;
		mdl_phase = PHASE_HUNT;
		mdl_v2 = 1'b0;
		mdl_pos = '0;
		mdl_len = '0;
		mdl_sig = 1'b0;
		mdl_ident = '0;
		mdl_frames = '0;
		mdl_malformed = '0;
		error_count = 0;
		bytes_sent = 0;
		cycle_count = 0;
		stall_left = 0;
		quiet = 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_header_extremes();
		test_short_payloads();
		test_capture_end();
		test_drain_pause();
		test_random_traffic();

		drain_records();
		repeat (SETTLE_CYCLES) @(posedge clk);
		@(negedge clk);
		if (error_count == 0 && expected_records.size() == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
